// ===== hdl/grc_pkg.sv =====
// grc_pkg: shared constants and the queued item type of the grid raycast column unit
// no dependencies
package grc_pkg;

  localparam int unsigned MAP_COLS    = 16;
  localparam int unsigned MAP_ROWS    = 16;
  localparam int unsigned SCREEN_COLS = 80;
  localparam int unsigned SCREEN_ROWS = 24;

  localparam int unsigned STEP_MAX    = MAP_COLS + MAP_ROWS + 2;
  localparam int unsigned STEP_CNT_W  = $clog2(STEP_MAX);

  localparam int unsigned NUM_W  = 32;
  localparam int unsigned DEN_W  = 40;
  localparam int unsigned SD_W   = 40;
  localparam int unsigned CAM_W  = 25;
  localparam int unsigned RAY_W  = 26;
  localparam int unsigned CELL_W = 6;

  localparam logic [31:0]     DELTA_SAT = 32'hFFFF_FFFF;
  localparam logic [SD_W-1:0] DIST_MIN  = SD_W'(7);
  localparam logic [31:0]     RECIP_NUM = 32'h2000_0000;

  typedef struct packed {
    logic        [6:0]  column;
    logic        [3:0]  cell_x;
    logic        [3:0]  cell_y;
    logic        [11:0] frac_x;
    logic        [11:0] frac_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
  } queue_item_t;

endpackage

// ===== hdl/grc_front.sv =====
// grc_front: accepts input beats, splits positions into cell and fraction, two-entry queue
// depends on grc_pkg
module grc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [6:0]          column_i,
  input  logic [15:0]         pos_x_i,
  input  logic [15:0]         pos_y_i,
  input  logic signed [15:0]  dir_x_i,
  input  logic signed [15:0]  dir_y_i,
  input  logic signed [15:0]  plane_x_i,
  input  logic signed [15:0]  plane_y_i,
  input  logic                pop_i,
  output logic                q_valid_o,
  output grc_pkg::queue_item_t q_item_o
);
  import grc_pkg::*;

  queue_item_t entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        push;
  queue_item_t new_item;

  always_comb begin
    new_item.column  = column_i;
    new_item.cell_x  = pos_x_i[15:12];
    new_item.cell_y  = pos_y_i[15:12];
    new_item.frac_x  = pos_x_i[11:0];
    new_item.frac_y  = pos_y_i[11:0];
    new_item.dir_x   = dir_x_i;
    new_item.dir_y   = dir_y_i;
    new_item.plane_x = plane_x_i;
    new_item.plane_y = plane_y_i;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !(pop_i && q_valid_o)) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i && q_valid_o) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i && q_valid_o) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ===== hdl/grc_div.sv =====
// grc_div: shared restoring divider, one quotient bit per cycle
// depends on grc_pkg
module grc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [grc_pkg::NUM_W-1:0]  num_i,
  input  logic [grc_pkg::DEN_W-1:0]  den_i,
  output logic                       done_o,
  output logic [grc_pkg::NUM_W-1:0]  quot_o
);
  import grc_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q, quot_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      quot_q <= {quot_q[NUM_W-2:0], fits};
      rem_q  <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    end
  end

endmodule

// ===== hdl/grc_back.sv =====
// grc_back: per-item sequencer, ray setup, grid walk, span and shade, output register
// depends on grc_pkg and grc_div
module grc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [255:0]                map_i,
  input  logic                        q_valid_i,
  input  grc_pkg::queue_item_t        q_item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [6:0]                  column_out_o,
  output logic [4:0]                  draw_start_o,
  output logic [4:0]                  draw_end_o,
  output logic [1:0]                  shade_o,
  output logic                        hit_side_o
);
  import grc_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_CAM   = 12'b000000000010,
    ST_RAYX  = 12'b000000000100,
    ST_RAYY  = 12'b000000001000,
    ST_DDX   = 12'b000000010000,
    ST_DDY   = 12'b000000100000,
    ST_SIDEX = 12'b000001000000,
    ST_SIDEY = 12'b000010000000,
    ST_WALK  = 12'b000100000000,
    ST_DIST  = 12'b001000000000,
    ST_LINE  = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_e;

  localparam logic [31:0] HALF_ROWS = 32'(SCREEN_ROWS / 2);
  localparam logic [31:0] LAST_ROW  = 32'(SCREEN_ROWS - 1);
  // ceil(2^40 / SCREEN_COLS) for the column to camera offset
  localparam logic [39:0] CAM_RECIP =
    40'(((64'd1 << 40) + 64'(SCREEN_COLS) - 64'd1) / 64'(SCREEN_COLS));

  state_e state_q, state_d;

  queue_item_t            item_q;
  logic signed [CAM_W-1:0] cam_q;
  logic signed [RAY_W-1:0] rx_q, ry_q;
  logic [31:0]            ddx_q, ddy_q, lh_q;
  logic [SD_W-1:0]        sdx_q, sdy_q, dist_q;
  logic signed [CELL_W-1:0] mx_q, my_q;
  logic                   side_q;
  logic [STEP_CNT_W-1:0]  cnt_q;
  logic                   out_valid_q;
  logic [6:0]             col_out_q;
  logic [4:0]             ds_q, de_q;
  logic [1:0]             shade_q;
  logic                   side_out_q;

  logic                   div_start, div_done;
  logic [NUM_W-1:0]       div_num, div_quot;
  logic [DEN_W-1:0]       div_den;

  logic [46:0]            cam_prod;
  logic signed [CAM_W+15:0] prod_x, prod_y;
  logic [RAY_W-1:0]       abs_rx, abs_ry;
  logic [12:0]            frac_x, frac_y;
  logic [44:0]            side_prod_x, side_prod_y;
  logic                   step_x, off_map, wall, walk_exit;
  logic signed [CELL_W-1:0] mx_n, my_n;
  logic [SD_W-1:0]        sdx_n, sdy_n, dist_raw, dist_c;
  logic [31:0]            half;
  logic [31:0]            ds_full, de_full;
  logic [1:0]             shade_c;
  logic                   out_free;

  grc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // column * 2^17 / SCREEN_COLS by reciprocal multiplication
  assign cam_prod = 47'(item_q.column) * 47'(CAM_RECIP);
  assign prod_x = $signed(item_q.plane_x) * cam_q;
  assign prod_y = $signed(item_q.plane_y) * cam_q;
  assign abs_rx = rx_q[RAY_W-1] ? RAY_W'(-rx_q) : RAY_W'(rx_q);
  assign abs_ry = ry_q[RAY_W-1] ? RAY_W'(-ry_q) : RAY_W'(ry_q);
  assign frac_x = rx_q[RAY_W-1] ? {1'b0, item_q.frac_x} : 13'd4096 - {1'b0, item_q.frac_x};
  assign frac_y = ry_q[RAY_W-1] ? {1'b0, item_q.frac_y} : 13'd4096 - {1'b0, item_q.frac_y};
  assign side_prod_x = 45'(frac_x) * 45'(ddx_q);
  assign side_prod_y = 45'(frac_y) * 45'(ddy_q);

  // one grid step
  assign step_x = (sdx_q < sdy_q);
  assign sdx_n  = sdx_q + SD_W'(ddx_q);
  assign sdy_n  = sdy_q + SD_W'(ddy_q);
  always_comb begin
    mx_n = mx_q;
    my_n = my_q;
    if (step_x) begin
      mx_n = rx_q[RAY_W-1] ? mx_q - CELL_W'(1) : mx_q + CELL_W'(1);
    end else begin
      my_n = ry_q[RAY_W-1] ? my_q - CELL_W'(1) : my_q + CELL_W'(1);
    end
  end
  assign off_map = mx_n[CELL_W-1] || my_n[CELL_W-1] ||
                   (mx_n >= $signed(CELL_W'(MAP_COLS))) ||
                   (my_n >= $signed(CELL_W'(MAP_ROWS)));
  assign wall      = map_i[{my_n[3:0], mx_n[3:0]}];
  assign walk_exit = off_map || wall || (cnt_q == STEP_CNT_W'(STEP_MAX - 1));

  assign dist_raw = side_q ? sdy_q - SD_W'(ddy_q) : sdx_q - SD_W'(ddx_q);
  assign dist_c   = (dist_raw < DIST_MIN) ? DIST_MIN : dist_raw;

  assign half    = {1'b0, lh_q[31:1]};
  assign ds_full = (half >= HALF_ROWS) ? 32'd0 : HALF_ROWS - half;
  assign de_full = (half >= LAST_ROW - HALF_ROWS) ? LAST_ROW : half + HALF_ROWS;

  always_comb begin
    if (dist_q < SD_W'(32'h0002_0000)) begin
      shade_c = side_q ? 2'd1 : 2'd0;
    end else if (dist_q < SD_W'(32'h0004_0000)) begin
      shade_c = 2'd1;
    end else if (dist_q < SD_W'(32'h0008_0000)) begin
      shade_c = 2'd2;
    end else begin
      shade_c = 2'd3;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = RECIP_NUM;
    div_den   = DEN_W'(abs_rx);
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = ST_CAM;
        end
      end
      ST_CAM: state_d = ST_RAYX;
      ST_RAYX: state_d = ST_RAYY;
      ST_RAYY: begin
        div_start = 1'b1;
        state_d   = ST_DDX;
      end
      ST_DDX: begin
        if (rx_q == '0 || div_done) begin
          div_start = 1'b1;
          div_den   = DEN_W'(abs_ry);
          state_d   = ST_DDY;
        end
      end
      ST_DDY: begin
        if (ry_q == '0 || div_done) begin
          state_d = ST_SIDEX;
        end
      end
      ST_SIDEX: state_d = ST_SIDEY;
      ST_SIDEY: state_d = ST_WALK;
      ST_WALK: begin
        if (walk_exit) begin
          state_d = ST_DIST;
        end
      end
      ST_DIST: state_d = ST_LINE;
      ST_LINE: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (state_q == ST_DIST) begin
      div_start = 1'b1;
      div_num   = NUM_W'(SCREEN_ROWS << 16);
      div_den   = DEN_W'(dist_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_valid_i) begin
      item_q <= q_item_i;
    end
    if (state_q == ST_CAM) begin
      cam_q <= $signed({1'b0, cam_prod[46:23]}) - $signed(CAM_W'(32'h0001_0000));
    end
    if (state_q == ST_RAYX) begin
      rx_q <= RAY_W'(item_q.dir_x) + RAY_W'($signed(prod_x[CAM_W+15:16]));
    end
    if (state_q == ST_RAYY) begin
      ry_q <= RAY_W'(item_q.dir_y) + RAY_W'($signed(prod_y[CAM_W+15:16]));
    end
    if (state_q == ST_DDX) begin
      ddx_q <= (rx_q == '0) ? DELTA_SAT : div_quot;
    end
    if (state_q == ST_DDY) begin
      ddy_q <= (ry_q == '0) ? DELTA_SAT : div_quot;
    end
    if (state_q == ST_SIDEX) begin
      sdx_q <= SD_W'(side_prod_x >> 12);
    end
    if (state_q == ST_SIDEY) begin
      sdy_q  <= SD_W'(side_prod_y >> 12);
      mx_q   <= CELL_W'(item_q.cell_x);
      my_q   <= CELL_W'(item_q.cell_y);
      side_q <= 1'b0;
      cnt_q  <= '0;
    end
    if (state_q == ST_WALK) begin
      cnt_q  <= cnt_q + STEP_CNT_W'(1);
      mx_q   <= mx_n;
      my_q   <= my_n;
      side_q <= !step_x;
      if (step_x) begin
        sdx_q <= sdx_n;
      end else begin
        sdy_q <= sdy_n;
      end
    end
    if (state_q == ST_DIST) begin
      dist_q <= dist_c;
    end
    if (state_q == ST_LINE && div_done) begin
      lh_q <= div_quot;
    end
    if (state_q == ST_OUT && out_free) begin
      col_out_q  <= item_q.column;
      ds_q       <= ds_full[4:0];
      de_q       <= de_full[4:0];
      shade_q    <= shade_c;
      side_out_q <= side_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign column_out_o = col_out_q;
  assign draw_start_o = ds_q;
  assign draw_end_o   = de_q;
  assign shade_o      = shade_q;
  assign hit_side_o   = side_out_q;

endmodule

// ===== hdl/grid_raycast_column_unit.sv =====
// grid_raycast_column_unit: top level, wall map registers, front queue and back sequencer
// depends on grc_pkg, grc_front, grc_back
// each beat runs ray setup, a walk of 1 to 34 grid steps, then span and shade
// each zero ray component skips the wait for its divider pass; a stalled output holds the sequencer
// the sequencer works on one beat at a time, through three divider passes and the walk
// a two-entry input queue takes new beats while a result waits at the output
// reset clears the wall map, the queue and the sequencer; no clearing pass
module grid_raycast_column_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [6:0]         column_i,
  input  logic [15:0]        pos_x_i,
  input  logic [15:0]        pos_y_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] plane_x_i,
  input  logic signed [15:0] plane_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         column_out_o,
  output logic [4:0]         draw_start_o,
  output logic [4:0]         draw_end_o,
  output logic [1:0]         shade_o,
  output logic               hit_side_o
);
  import grc_pkg::*;

  logic [63:0]  map_q [4];
  logic [255:0] map_flat;
  logic         q_valid, q_pop;
  queue_item_t  q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        map_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      map_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign map_flat = {map_q[3], map_q[2], map_q[1], map_q[0]};

  grc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .column_i   (column_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .dir_x_i    (dir_x_i),
    .dir_y_i    (dir_y_i),
    .plane_x_i  (plane_x_i),
    .plane_y_i  (plane_y_i),
    .pop_i      (q_pop),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item)
  );

  grc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .map_i        (map_flat),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .column_out_o (column_out_o),
    .draw_start_o (draw_start_o),
    .draw_end_o   (draw_end_o),
    .shade_o      (shade_o),
    .hit_side_o   (hit_side_o)
  );

endmodule

// ===== hdl/grc_checker.sv =====
// grc_port_checker: port-level checks of the grid raycast column unit, bound to the top level
// depends on grc_pkg
module grc_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [6:0] column_out_o,
  input logic [4:0] draw_start_o,
  input logic [4:0] draw_end_o,
  input logic [1:0] shade_o,
  input logic       hit_side_o
);
  import grc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(column_out_o) && $stable(draw_start_o))
    else $error("stalled result changed");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> draw_start_o <= draw_end_o)
    else $error("wall span inverted");

  a_side_dim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_side_o |-> shade_o != 2'd0)
    else $error("y side not dimmed");

endmodule

bind grid_raycast_column_unit grc_port_checker u_grc_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .column_out_o (column_out_o),
  .draw_start_o (draw_start_o),
  .draw_end_o   (draw_end_o),
  .shade_o      (shade_o),
  .hit_side_o   (hit_side_o)
);
